@@ rtl/core/jlud_pkg.sv @@
// Shared types, character codes and decode helpers of the JSON line unescape deframer.
package jlud_pkg;

  // Count width, sized for the largest supported line store (64 bytes).
  localparam int unsigned LenW = 7;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLowB    = 8'h62;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChLowN    = 8'h6E;
  localparam logic [7:0] ChLowR    = 8'h72;
  localparam logic [7:0] ChLowT    = 8'h74;
  localparam logic [7:0] ChLowU    = 8'h75;

  // Top six bits of a high (D800..DBFF) and a low (DC00..DFFF) surrogate.
  localparam logic [5:0]  HiSurPfx = 6'b110110;
  localparam logic [5:0]  LoSurPfx = 6'b110111;
  localparam logic [20:0] SuppBase = 21'h10000;

  // One finished line handed from the front to the back.
  typedef struct packed {
    logic            bank;
    logic [LenW-1:0] count;
    logic [LenW-1:0] raw_len;
    logic            ovf;
  } line_desc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  // Single-character escapes; the \u escape is handled by the caller.
  function automatic esc_t esc_map(input logic [7:0] e);
    esc_t r;
    r.ok = 1'b1;
    case (e)
      ChQuote:  r.ch = ChQuote;
      ChBslash: r.ch = ChBslash;
      ChSlash:  r.ch = ChSlash;
      ChLowB:   r.ch = 8'h08;
      ChLowF:   r.ch = 8'h0C;
      ChLowN:   r.ch = 8'h0A;
      ChLowR:   r.ch = 8'h0D;
      ChLowT:   r.ch = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.ch = 8'h00;
      end
    endcase
    return r;
  endfunction

  // Number of UTF-8 bytes minus one.
  function automatic logic [1:0] utf8_last(input logic [20:0] cp);
    logic [1:0] r;
    if (cp < 21'h80) begin
      r = 2'd0;
    end else if (cp < 21'h800) begin
      r = 2'd1;
    end else if (cp < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (last)
      2'd0: r = {1'b0, cp[6:0]};
      2'd1: begin
        case (idx)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/jlud_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module jlud_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/jlud_front.sv @@
// Front end: accepts received bytes, fills the raw line banks and queues finished lines.
module jlud_front #(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic                          line_done_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_LINE):0]     wr_addr_o,
  output logic [7:0]                    wr_data_o,
  output logic                          push_o,
  output jlud_pkg::line_desc_t          desc_o
);

  localparam int unsigned AddrW = $clog2(MAX_LINE);

  logic [1:0]                  inflight_q, inflight_d;
  logic                        bank_q, bank_d;
  logic [jlud_pkg::LenW-1:0]   cnt_q, cnt_d;
  logic [jlud_pkg::LenW-1:0]   zpos_q, zpos_d;
  logic                        zseen_q, zseen_d;
  logic                        ovf_q, ovf_d;
  logic                        accept, is_nl, room;

  assign rx_ready_o = (inflight_q != 2'd2);
  assign accept     = rx_valid_i & rx_ready_o;
  assign is_nl      = (rx_byte_i == jlud_pkg::ChNewline);
  assign room       = (cnt_q < jlud_pkg::LenW'(MAX_LINE));

  assign wr_en_o   = accept & ~is_nl & room;
  assign wr_addr_o = {bank_q, cnt_q[AddrW-1:0]};
  assign wr_data_o = rx_byte_i;
  assign push_o    = accept & is_nl;

  always_comb begin
    desc_o.bank    = bank_q;
    desc_o.count   = cnt_q;
    desc_o.raw_len = zseen_q ? zpos_q : cnt_q;
    desc_o.ovf     = ovf_q;
  end

  always_comb begin
    inflight_d = inflight_q + {1'b0, push_o} - {1'b0, line_done_i};
    bank_d     = bank_q;
    cnt_d      = cnt_q;
    zpos_d     = zpos_q;
    zseen_d    = zseen_q;
    ovf_d      = ovf_q;
    if (push_o) begin
      bank_d  = ~bank_q;
      cnt_d   = '0;
      zseen_d = 1'b0;
      ovf_d   = 1'b0;
    end else if (accept) begin
      if (room) begin
        cnt_d = cnt_q + jlud_pkg::LenW'(1);
        if (rx_byte_i == 8'h00 && !zseen_q) begin
          zseen_d = 1'b1;
          zpos_d  = cnt_q;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 2'd0;
      bank_q     <= 1'b0;
      cnt_q      <= '0;
      zpos_q     <= '0;
      zseen_q    <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      bank_q     <= bank_d;
      cnt_q      <= cnt_d;
      zpos_q     <= zpos_d;
      zseen_q    <= zseen_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

@@ rtl/core/jlud_fifo.sv @@
// Two-entry queue of finished line descriptors between front and back.
module jlud_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jlud_pkg::line_desc_t data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output jlud_pkg::line_desc_t data_o
);

  jlud_pkg::line_desc_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ rtl/core/jlud_back.sv @@
// Back end: decodes one stored line, then drains the message.
module jlud_back #(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_valid_i,
  input  jlud_pkg::line_desc_t          desc_i,
  output logic                          pop_o,
  output logic [$clog2(MAX_LINE):0]     raw_rd_addr_o,
  input  logic [7:0]                    raw_rd_data_i,
  output logic                          dec_wr_en_o,
  output logic [$clog2(MAX_LINE)-1:0]   dec_wr_addr_o,
  output logic [7:0]                    dec_wr_data_o,
  output logic [$clog2(MAX_LINE)-1:0]   dec_rd_addr_o,
  input  logic [7:0]                    dec_rd_data_i,
  output logic                          line_done_o,
  output logic [7:0]                    msg_byte_o,
  output logic                          last_byte_o,
  output logic                          empty_msg_o,
  output logic                          raw_fallback_o,
  output logic                          line_truncated_o,
  output logic                          msg_valid_o,
  input  logic                          msg_ready_i
);

  localparam int unsigned AddrW = $clog2(MAX_LINE);
  localparam int unsigned LenW  = jlud_pkg::LenW;

  typedef enum logic [2:0] {
    StIdle, StOpen, StNorm, StEsc, StHex, StPair, StUtf, StEmit
  } state_e;

  state_e          state_q, state_d;
  logic            bank_q, bank_d;
  logic [LenW-1:0] n_q, n_d;
  logic [LenW-1:0] rawlen_q, rawlen_d;
  logic            ovf_q, ovf_d;
  logic [LenW-1:0] i_q, i_d;
  logic [LenW-1:0] j_q, j_d;
  logic [2:0]      step_q, step_d;
  logic [20:0]     cp_q, cp_d;
  logic [15:0]     lo_q, lo_d;
  logic [1:0]      ulast_q, ulast_d;
  logic [1:0]      uidx_q, uidx_d;
  logic [LenW-1:0] dcnt_q, dcnt_d;
  logic [LenW-1:0] dzpos_q, dzpos_d;
  logic            dzseen_q, dzseen_d;
  logic            raw_q, raw_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;
  logic            oempty_q, oempty_d;
  logic            oraw_q, oraw_d;
  logic            otrunc_q, otrunc_d;

  logic                 put_en;
  logic [7:0]           put_byte;
  logic                 fin_ok, fin_fail;
  logic                 in_range;
  logic [7:0]           c;
  jlud_pkg::hex_digit_t hx;
  jlud_pkg::esc_t       esc;
  logic [20:0]          cp_hex;
  logic [15:0]          lo_new;
  logic                 unpaired;

  assign c        = raw_rd_data_i;
  assign in_range = (i_q < n_q);
  assign hx       = jlud_pkg::hex_decode(c);
  assign esc      = jlud_pkg::esc_map(c);
  assign cp_hex   = {5'b0, cp_q[11:0], hx.val};
  assign lo_new   = {lo_q[11:0], hx.val};

  always_comb begin
    state_d  = state_q;
    bank_d   = bank_q;
    n_d      = n_q;
    rawlen_d = rawlen_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    step_d   = step_q;
    cp_d     = cp_q;
    lo_d     = lo_q;
    ulast_d  = ulast_q;
    uidx_d   = uidx_q;
    dcnt_d   = dcnt_q;
    dzpos_d  = dzpos_q;
    dzseen_d = dzseen_q;
    raw_d    = raw_q;
    len_d    = len_q;
    ovalid_d = ovalid_q & ~msg_ready_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oempty_d = oempty_q;
    oraw_d   = oraw_q;
    otrunc_d = otrunc_q;
    pop_o       = 1'b0;
    line_done_o = 1'b0;
    put_en      = 1'b0;
    put_byte    = 8'h00;
    fin_ok      = 1'b0;
    fin_fail    = 1'b0;
    unpaired    = 1'b0;
    dec_wr_en_o   = 1'b0;
    dec_wr_addr_o = dcnt_q[AddrW-1:0];
    dec_wr_data_o = 8'h00;

    case (state_q)
      StIdle: begin
        if (desc_valid_i) begin
          pop_o    = 1'b1;
          bank_d   = desc_i.bank;
          n_d      = desc_i.count;
          rawlen_d = desc_i.raw_len;
          ovf_d    = desc_i.ovf;
          i_d      = '0;
          dcnt_d   = '0;
          dzseen_d = 1'b0;
          state_d  = StOpen;
        end
      end
      StOpen: begin
        if (n_q < LenW'(2) || c != jlud_pkg::ChQuote) begin
          fin_fail = 1'b1;
        end else begin
          i_d     = LenW'(1);
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (!in_range) begin
          fin_fail = 1'b1;
        end else if (c == jlud_pkg::ChQuote) begin
          fin_ok = 1'b1;
        end else if (c != jlud_pkg::ChBslash) begin
          put_en   = 1'b1;
          put_byte = c;
          i_d      = i_q + LenW'(1);
        end else if (i_q + LenW'(1) >= n_q) begin
          fin_fail = 1'b1;
        end else begin
          i_d     = i_q + LenW'(1);
          state_d = StEsc;
        end
      end
      StEsc: begin
        i_d = i_q + LenW'(1);
        if (c == jlud_pkg::ChLowU) begin
          cp_d    = '0;
          step_d  = 3'd0;
          state_d = StHex;
        end else if (esc.ok) begin
          put_en   = 1'b1;
          put_byte = esc.ch;
          state_d  = StNorm;
        end else begin
          fin_fail = 1'b1;
        end
      end
      StHex: begin
        if (!in_range || !hx.ok) begin
          fin_fail = 1'b1;
        end else begin
          cp_d = cp_hex;
          i_d  = i_q + LenW'(1);
          if (step_q == 3'd3) begin
            if (cp_hex[15:10] == jlud_pkg::HiSurPfx) begin
              j_d     = i_q + LenW'(1);
              step_d  = 3'd0;
              lo_d    = '0;
              state_d = StPair;
            end else begin
              ulast_d = jlud_pkg::utf8_last(cp_hex);
              uidx_d  = 2'd0;
              state_d = StUtf;
            end
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      StPair: begin
        // Look ahead for a low surrogate escape; rewind on any mismatch.
        if (!in_range) begin
          unpaired = 1'b1;
        end else if (step_q == 3'd0) begin
          unpaired = (c != jlud_pkg::ChBslash);
        end else if (step_q == 3'd1) begin
          unpaired = (c != jlud_pkg::ChLowU);
        end else if (!hx.ok) begin
          unpaired = 1'b1;
        end else if (step_q == 3'd5 && lo_new[15:10] != jlud_pkg::LoSurPfx) begin
          unpaired = 1'b1;
        end

        if (unpaired) begin
          i_d     = j_q;
          ulast_d = jlud_pkg::utf8_last(cp_q);
          uidx_d  = 2'd0;
          state_d = StUtf;
        end else begin
          i_d    = i_q + LenW'(1);
          lo_d   = lo_new;
          step_d = step_q + 3'd1;
          if (step_q == 3'd5) begin
            cp_d    = jlud_pkg::SuppBase + {1'b0, cp_q[9:0], lo_new[9:0]};
            ulast_d = 2'd3;
            uidx_d  = 2'd0;
            state_d = StUtf;
          end
        end
      end
      StUtf: begin
        put_en   = 1'b1;
        put_byte = jlud_pkg::utf8_byte(cp_q, ulast_q, uidx_q);
        uidx_d   = uidx_q + 2'd1;
        if (uidx_q == ulast_q) begin
          state_d = StNorm;
        end
      end
      StEmit: begin
        if (!ovalid_q || msg_ready_i) begin
          ovalid_d = 1'b1;
          oraw_d   = raw_q;
          otrunc_d = ovf_q;
          if (len_q == '0) begin
            obyte_d     = 8'h00;
            olast_d     = 1'b1;
            oempty_d    = 1'b1;
            line_done_o = 1'b1;
            state_d     = StIdle;
          end else begin
            obyte_d  = raw_q ? raw_rd_data_i : dec_rd_data_i;
            olast_d  = (i_q + LenW'(1) == len_q);
            oempty_d = 1'b0;
            i_d      = i_q + LenW'(1);
            if (i_q + LenW'(1) == len_q) begin
              line_done_o = 1'b1;
              state_d     = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (put_en && dcnt_q < LenW'(MAX_LINE)) begin
      dec_wr_en_o   = 1'b1;
      dec_wr_data_o = put_byte;
      dcnt_d        = dcnt_q + LenW'(1);
      if (put_byte == 8'h00 && !dzseen_q) begin
        dzseen_d = 1'b1;
        dzpos_d  = dcnt_q;
      end
    end

    if (fin_ok || fin_fail) begin
      raw_d   = fin_fail;
      len_d   = fin_fail ? rawlen_q : (dzseen_q ? dzpos_q : dcnt_q);
      i_d     = '0;
      state_d = StEmit;
    end
  end

  // Present the next pointer so the read data always matches i_q.
  assign raw_rd_addr_o = {bank_d, i_d[AddrW-1:0]};
  assign dec_rd_addr_o = i_d[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      bank_q   <= 1'b0;
      n_q      <= '0;
      rawlen_q <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      step_q   <= 3'd0;
      cp_q     <= '0;
      lo_q     <= '0;
      ulast_q  <= 2'd0;
      uidx_q   <= 2'd0;
      dcnt_q   <= '0;
      dzpos_q  <= '0;
      dzseen_q <= 1'b0;
      raw_q    <= 1'b0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
      obyte_q  <= 8'h00;
      olast_q  <= 1'b0;
      oempty_q <= 1'b0;
      oraw_q   <= 1'b0;
      otrunc_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bank_q   <= bank_d;
      n_q      <= n_d;
      rawlen_q <= rawlen_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      step_q   <= step_d;
      cp_q     <= cp_d;
      lo_q     <= lo_d;
      ulast_q  <= ulast_d;
      uidx_q   <= uidx_d;
      dcnt_q   <= dcnt_d;
      dzpos_q  <= dzpos_d;
      dzseen_q <= dzseen_d;
      raw_q    <= raw_d;
      len_q    <= len_d;
      ovalid_q <= ovalid_d;
      obyte_q  <= obyte_d;
      olast_q  <= olast_d;
      oempty_q <= oempty_d;
      oraw_q   <= oraw_d;
      otrunc_q <= otrunc_d;
    end
  end

  assign msg_valid_o      = ovalid_q;
  assign msg_byte_o       = obyte_q;
  assign last_byte_o      = olast_q;
  assign empty_msg_o      = oempty_q;
  assign raw_fallback_o   = oraw_q;
  assign line_truncated_o = otrunc_q;

endmodule

@@ rtl/core/json_line_unescape_deframer_top.sv @@
// Top level of the JSON line unescape deframer: front, line queue, back and line stores.
// Input: one byte per cycle while a raw line bank is free; two banks let a line fill
//   while the previous one is decoded and drained.
// Decode: the newline pushes a descriptor into the line queue; the back pops it when idle
//   and walks the raw bytes, emitting code points and rewinding after a rejected pair.
// Output: one transfer per cycle while draining, unless msg_ready_i stalls it.
// Reset: asynchronous, active low; clears counters and state, stores are left as they are.
module json_line_unescape_deframer_top #(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  output logic [7:0] msg_byte_o,
  output logic       last_byte_o,
  output logic       empty_msg_o,
  output logic       raw_fallback_o,
  output logic       line_truncated_o,
  output logic       msg_valid_o,
  input  logic       msg_ready_i
);

  localparam int unsigned AddrW    = $clog2(MAX_LINE);
  localparam int unsigned DecDepth = 1 << AddrW;
  localparam int unsigned RawDepth = 2 * DecDepth;

  // Raw line bank write side (front) and read side (back).
  logic             raw_we;
  logic [AddrW:0]   raw_waddr;
  logic [7:0]       raw_wdata;
  logic [AddrW:0]   raw_raddr;
  logic [7:0]       raw_rdata;

  // Decoded line store, written and read by the back only.
  logic             dec_we;
  logic [AddrW-1:0] dec_waddr;
  logic [7:0]       dec_wdata;
  logic [AddrW-1:0] dec_raddr;
  logic [7:0]       dec_rdata;

  // Finished-line descriptors travelling from front to back.
  logic                 push, pop, desc_valid, line_done;
  jlud_pkg::line_desc_t push_desc, pop_desc;

  // Accept bytes, fill the current bank and hand the line on at newline.
  jlud_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .line_done_i(line_done),
    .wr_en_o    (raw_we),
    .wr_addr_o  (raw_waddr),
    .wr_data_o  (raw_wdata),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  // Hold finished lines until the back is free.
  jlud_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_desc),
    .pop_i  (pop),
    .valid_o(desc_valid),
    .data_o (pop_desc)
  );

  jlud_ram #(
    .Width(8),
    .Depth(RawDepth)
  ) u_raw_ram (
    .clk_i  (clk_i),
    .we_i   (raw_we),
    .waddr_i(raw_waddr),
    .wdata_i(raw_wdata),
    .raddr_i(raw_raddr),
    .rdata_o(raw_rdata)
  );

  jlud_ram #(
    .Width(8),
    .Depth(DecDepth)
  ) u_dec_ram (
    .clk_i  (clk_i),
    .we_i   (dec_we),
    .waddr_i(dec_waddr),
    .wdata_i(dec_wdata),
    .raddr_i(dec_raddr),
    .rdata_o(dec_rdata)
  );

  // Decode the oldest line, then drain decoded or raw bytes through the output register.
  jlud_back #(
    .MAX_LINE(MAX_LINE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_valid_i    (desc_valid),
    .desc_i          (pop_desc),
    .pop_o           (pop),
    .raw_rd_addr_o   (raw_raddr),
    .raw_rd_data_i   (raw_rdata),
    .dec_wr_en_o     (dec_we),
    .dec_wr_addr_o   (dec_waddr),
    .dec_wr_data_o   (dec_wdata),
    .dec_rd_addr_o   (dec_raddr),
    .dec_rd_data_i   (dec_rdata),
    .line_done_o     (line_done),
    .msg_byte_o      (msg_byte_o),
    .last_byte_o     (last_byte_o),
    .empty_msg_o     (empty_msg_o),
    .raw_fallback_o  (raw_fallback_o),
    .line_truncated_o(line_truncated_o),
    .msg_valid_o     (msg_valid_o),
    .msg_ready_i     (msg_ready_i)
  );

endmodule

@@ rtl/core/jlud_checker.sv @@
// Port-level checker for the JSON line unescape deframer, bound to its top level.
module jlud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] rx_byte_i,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic [7:0] msg_byte_o,
  input logic       last_byte_o,
  input logic       empty_msg_o,
  input logic       raw_fallback_o,
  input logic       line_truncated_o,
  input logic       msg_valid_o,
  input logic       msg_ready_i
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && !msg_ready_i |=> msg_valid_o)
    else $error("output valid dropped before transfer");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && !msg_ready_i |=> $stable(msg_byte_o) && $stable(last_byte_o)
      && $stable(empty_msg_o))
    else $error("output payload changed while stalled");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && empty_msg_o |-> last_byte_o && msg_byte_o == 8'h00)
    else $error("empty message not a single zero result");

  a_no_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && !empty_msg_o |-> msg_byte_o != 8'h00)
    else $error("zero byte delivered inside a message");

  a_flags_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && msg_ready_i && !last_byte_o ##1 msg_valid_o |->
      $stable(raw_fallback_o) && $stable(line_truncated_o))
    else $error("message flags changed within a message");

endmodule

bind json_line_unescape_deframer_top jlud_checker u_jlud_checker (.*);
